// ===== design/dcd_pkg.sv =====
// Package for the directed cycle detector: widths, sizes, command codes,
// sequencer state encoding and the result record passed to the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dcd_pkg;

    localparam int MAX_VERTS   = 1024;
    localparam int MAX_EDGES   = 4096;
    localparam int VERT_W      = $clog2(MAX_VERTS);      // vertex number
    localparam int EADDR_W     = $clog2(MAX_EDGES);      // edge store address
    localparam int PTR_W       = EADDR_W + 1;            // edge index + 1, 0 = end of list
    localparam int CNT_W       = VERT_W + 1;             // root count, stack depth
    localparam int FRAME_W     = VERT_W + PTR_W;         // stack frame and edge entry
    localparam int MARK_W      = 2;                      // {visited, on_path}

    localparam logic [CNT_W-1:0] VERTS_LIMIT = CNT_W'(MAX_VERTS);
    localparam logic [PTR_W-1:0] EDGES_LIMIT = PTR_W'(MAX_EDGES);

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_DETECT = 1'b1;

    localparam logic [MARK_W-1:0] MARK_CLEAR   = 2'b00;
    localparam logic [MARK_W-1:0] MARK_ON_PATH = 2'b11;
    localparam logic [MARK_W-1:0] MARK_DONE    = 2'b10;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_WR,
        ST_ROOT,
        ST_ROOT_CHK,
        ST_PUSH,
        ST_PUSH_HD,
        ST_WALK,
        ST_POP_RD,
        ST_EDGE_RD,
        ST_EDGE_CHK,
        ST_FINISH
    } dcd_state_t;

    typedef struct packed {
        logic done;
        logic cycle_found;
        logic edges_dropped;
    } dcd_result_t;

endpackage

`default_nettype wire

// ===== design/directed_cycle_detect.sv =====
// Top level of the directed cycle detector: vertex count register, result
// register and the search sequencer.
// Depends on dcd_pkg and dcd_seq.
//
//   Channel   Signals                                    Direction
//   input     in_valid/in_ready, command, src_vertex,    into block
//             dst_vertex
//   output    out_valid/out_ready, cycle_found,          out of block
//             edges_dropped
//   config    cfg_wr_en, cfg_wr_data (vertex count)      into block
//
// An add-edge word is written in ST_ADD_WR before the next word is taken. A
// detect word tries roots, pushes vertices and walks edges, paced by the
// single read port of each adjacency memory, then sweeps all MAX_VERTS entries
// to empty the head table and the marks. After reset the same sweep runs
// before the first word is taken. A result waiting on out_ready does not stop
// edge loading; only the next detect waits for the result register to free up.
`timescale 1ns / 1ps
`default_nettype none

module directed_cycle_detect (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        command,
    input  wire logic [dcd_pkg::VERT_W-1:0]  src_vertex,
    input  wire logic [dcd_pkg::VERT_W-1:0]  dst_vertex,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             cycle_found,
    output logic                             edges_dropped,
    input  wire logic                        cfg_wr_en,
    input  wire logic [dcd_pkg::CNT_W-1:0]   cfg_wr_data
);

    import dcd_pkg::*;

    logic [CNT_W-1:0] vcount_reg, vcount_next;
    logic             out_valid_reg, out_valid_next;
    logic             found_reg, found_next;
    logic             dropped_reg, dropped_next;
    logic             slot_free;
    dcd_result_t      result;

    assign slot_free = !out_valid_reg || out_ready;

    dcd_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .src_vertex   (src_vertex),
        .dst_vertex   (dst_vertex),
        .vertex_count (vcount_reg),
        .slot_free    (slot_free),
        .result       (result)
    );

    always_comb
    begin
        vcount_next    = cfg_wr_en ? cfg_wr_data : vcount_reg;
        out_valid_next = out_valid_reg && !out_ready;
        found_next     = found_reg;
        dropped_next   = dropped_reg;
        if (result.done)
        begin
            out_valid_next = 1'b1;
            found_next     = result.cycle_found;
            dropped_next   = result.edges_dropped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vcount_reg    <= vcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg   <= found_next;
        dropped_reg <= dropped_next;
    end

    assign out_valid     = out_valid_reg;
    assign cycle_found   = found_reg;
    assign edges_dropped = dropped_reg;

endmodule

`default_nettype wire

// ===== design/dcd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dcd_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/dcd_seq.sv =====
// Sequencer of the cycle detector: edge loading, iterative depth-first search
// over the adjacency memories with an explicit stack, and the clearing sweep.
// Depends on dcd_pkg and dcd_ram.
`timescale 1ns / 1ps
`default_nettype none

module dcd_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        command,
    input  wire logic [dcd_pkg::VERT_W-1:0]  src_vertex,
    input  wire logic [dcd_pkg::VERT_W-1:0]  dst_vertex,
    input  wire logic [dcd_pkg::CNT_W-1:0]   vertex_count,
    input  wire logic                        slot_free,
    output dcd_pkg::dcd_result_t             result
);

    import dcd_pkg::*;

    dcd_state_t         state_reg, state_next;
    logic [VERT_W-1:0]  src_reg, src_next;
    logic [VERT_W-1:0]  dst_reg, dst_next;
    logic [CNT_W-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]   depth_reg, depth_next;
    logic [VERT_W-1:0]  top_v_reg, top_v_next;
    logic [PTR_W-1:0]   top_ptr_reg, top_ptr_next;
    logic [VERT_W-1:0]  push_v_reg, push_v_next;
    logic [PTR_W-1:0]   total_reg, total_next;
    logic               ovf_reg, ovf_next;
    logic               found_reg, found_next;
    logic [VERT_W-1:0]  clr_cnt_reg, clr_cnt_next;

    logic               head_we;
    logic [VERT_W-1:0]  head_waddr, head_raddr;
    logic [PTR_W-1:0]   head_wdata, head_rdata;
    logic               edge_we;
    logic [EADDR_W-1:0] edge_waddr, edge_raddr;
    logic [FRAME_W-1:0] edge_wdata, edge_rdata;
    logic               mark_we;
    logic [VERT_W-1:0]  mark_waddr, mark_raddr;
    logic [MARK_W-1:0]  mark_wdata, mark_rdata;
    logic               stack_we;
    logic [VERT_W-1:0]  stack_waddr, stack_raddr;
    logic [FRAME_W-1:0] stack_wdata, stack_rdata;

    logic [CNT_W-1:0]   depth_m1, depth_m2;
    logic [PTR_W-1:0]   ptr_m1;
    logic               root_ok, list_end, in_fire;

    assign depth_m1 = depth_reg - CNT_W'(1);
    assign depth_m2 = depth_reg - CNT_W'(2);
    assign ptr_m1   = top_ptr_reg - PTR_W'(1);
    assign root_ok  = (root_reg < vertex_count) && (root_reg < VERTS_LIMIT);
    assign list_end = (top_ptr_reg == '0) || (top_ptr_reg > EDGES_LIMIT);
    assign in_fire  = in_valid && in_ready;

    dcd_ram #(.DEPTH(MAX_VERTS), .WIDTH(PTR_W)) u_heads (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    dcd_ram #(.DEPTH(MAX_EDGES), .WIDTH(FRAME_W)) u_edges (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    dcd_ram #(.DEPTH(MAX_VERTS), .WIDTH(MARK_W)) u_marks (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    dcd_ram #(.DEPTH(MAX_VERTS), .WIDTH(FRAME_W)) u_stack (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == VERT_W'(MAX_VERTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_DETECT)
                    begin
                        state_next = ST_ROOT;
                    end
                    else if (total_reg != EDGES_LIMIT)
                    begin
                        state_next = ST_ADD_WR;
                    end
                end
            end
            ST_ADD_WR:   state_next = ST_IDLE;
            ST_ROOT:     state_next = root_ok ? ST_ROOT_CHK : ST_FINISH;
            ST_ROOT_CHK: state_next = mark_rdata[1] ? ST_ROOT : ST_PUSH;
            ST_PUSH:     state_next = ST_PUSH_HD;
            ST_PUSH_HD:  state_next = ST_WALK;
            ST_WALK:
            begin
                if (!list_end)
                begin
                    state_next = ST_EDGE_RD;
                end
                else if (depth_reg == CNT_W'(1))
                begin
                    state_next = ST_ROOT;
                end
                else
                begin
                    state_next = ST_POP_RD;
                end
            end
            ST_POP_RD:   state_next = ST_WALK;
            ST_EDGE_RD:  state_next = ST_EDGE_CHK;
            ST_EDGE_CHK:
            begin
                if (!mark_rdata[1])
                begin
                    state_next = (depth_reg < VERTS_LIMIT) ? ST_PUSH : ST_WALK;
                end
                else if (mark_rdata[0])
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_CLEAR;
                end
            end
            default:     state_next = ST_CLEAR;
        endcase
    end

    // Datapath updates and memory controls.
    always_comb
    begin
        src_next     = src_reg;
        dst_next     = dst_reg;
        root_next    = root_reg;
        depth_next   = depth_reg;
        top_v_next   = top_v_reg;
        top_ptr_next = top_ptr_reg;
        push_v_next  = push_v_reg;
        total_next   = total_reg;
        ovf_next     = ovf_reg;
        found_next   = found_reg;
        clr_cnt_next = clr_cnt_reg;
        in_ready     = 1'b0;
        result       = '{done: 1'b0, cycle_found: found_reg, edges_dropped: ovf_reg};

        head_we     = 1'b0;
        head_waddr  = src_reg;
        head_wdata  = total_reg;
        head_raddr  = push_v_reg;
        edge_we     = 1'b0;
        edge_waddr  = total_reg[EADDR_W-1:0];
        edge_wdata  = {dst_reg, head_rdata};
        edge_raddr  = ptr_m1[EADDR_W-1:0];
        mark_we     = 1'b0;
        mark_waddr  = push_v_reg;
        mark_wdata  = MARK_ON_PATH;
        mark_raddr  = root_reg[VERT_W-1:0];
        stack_we    = 1'b0;
        stack_waddr = depth_m1[VERT_W-1:0];
        stack_wdata = {top_v_reg, top_ptr_reg};
        stack_raddr = depth_m2[VERT_W-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                head_we      = 1'b1;
                head_waddr   = clr_cnt_reg;
                head_wdata   = '0;
                mark_we      = 1'b1;
                mark_waddr   = clr_cnt_reg;
                mark_wdata   = MARK_CLEAR;
                clr_cnt_next = clr_cnt_reg + VERT_W'(1);
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                // The head of the source list is read as the word is taken.
                head_raddr = src_vertex;
                if (in_fire)
                begin
                    src_next = src_vertex;
                    dst_next = dst_vertex;
                    if (command == CMD_DETECT)
                    begin
                        root_next  = '0;
                        depth_next = '0;
                    end
                    else if (total_reg == EDGES_LIMIT)
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_ADD_WR:
            begin
                edge_we    = 1'b1;
                head_we    = 1'b1;
                head_wdata = total_reg + PTR_W'(1);
                total_next = total_reg + PTR_W'(1);
            end
            ST_ROOT:
            begin
                push_v_next = root_reg[VERT_W-1:0];
                if (!root_ok)
                begin
                    found_next = 1'b0;
                end
            end
            ST_ROOT_CHK:
            begin
                if (mark_rdata[1])
                begin
                    root_next = root_reg + CNT_W'(1);
                end
            end
            ST_PUSH:
            begin
                mark_we    = 1'b1;
                stack_we   = (depth_reg != '0);
                top_v_next = push_v_reg;
                depth_next = depth_reg + CNT_W'(1);
            end
            ST_PUSH_HD:
            begin
                top_ptr_next = head_rdata;
            end
            ST_WALK:
            begin
                if (list_end)
                begin
                    // Vertex is finished: it leaves the path and the frame pops.
                    mark_we    = 1'b1;
                    mark_waddr = top_v_reg;
                    mark_wdata = MARK_DONE;
                    depth_next = depth_m1;
                    if (depth_reg == CNT_W'(1))
                    begin
                        root_next = root_reg + CNT_W'(1);
                    end
                end
            end
            ST_POP_RD:
            begin
                {top_v_next, top_ptr_next} = stack_rdata;
            end
            ST_EDGE_RD:
            begin
                {push_v_next, top_ptr_next} = edge_rdata;
                mark_raddr = edge_rdata[FRAME_W-1:PTR_W];
            end
            ST_EDGE_CHK:
            begin
                if (mark_rdata[1] && mark_rdata[0])
                begin
                    found_next = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    result.done  = 1'b1;
                    total_next   = '0;
                    ovf_next     = 1'b0;
                    clr_cnt_next = '0;
                end
            end
            default:
            begin
                clr_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            total_reg   <= '0;
            ovf_reg     <= 1'b0;
            found_reg   <= 1'b0;
            root_reg    <= '0;
            depth_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            total_reg   <= total_next;
            ovf_reg     <= ovf_next;
            found_reg   <= found_next;
            root_reg    <= root_next;
            depth_reg   <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        top_v_reg   <= top_v_next;
        top_ptr_reg <= top_ptr_next;
        push_v_reg  <= push_v_next;
    end

endmodule

`default_nettype wire

// ===== sim/tb_directed_cycle_detect.sv =====
// Testbench for directed_cycle_detect: loads edge words, issues detect words and
// checks every result against a cycle-detection predictor kept in the testbench.
// Depends on dcd_pkg and the directed_cycle_detect RTL.
`timescale 1ns / 1ps

module tb_directed_cycle_detect;

    import dcd_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int SETTLE_CYCLES = 1100;    // covers the sweep that empties the graph
    localparam int STALL_LIMIT   = 100000;
    localparam int PHASE_WORDS   = 150;

    // Graph shapes used by the random part.
    localparam int SHAPE_DAG      = 0;
    localparam int SHAPE_DAG_BACK = 1;
    localparam int SHAPE_ANY      = 2;
    localparam int SHAPE_RING     = 3;

    typedef struct packed {
        logic cycle;
        logic lost;
    } verdict_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               command = CMD_ADD;
    logic [VERT_W-1:0]  src_vertex = '0;
    logic [VERT_W-1:0]  dst_vertex = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               cycle_found;
    logic               edges_dropped;
    logic               cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]   cfg_wr_data = '0;

    // Predictor state: adjacency lists, search marks and the root count.
    logic [PTR_W-1:0]   adj_head [MAX_VERTS];
    logic [VERT_W-1:0]  arc_dst [MAX_EDGES];
    logic [PTR_W-1:0]   arc_next [MAX_EDGES];
    int                 arc_count = 0;
    logic               arcs_lost = 1'b0;
    int                 root_limit = 0;
    bit                 seen [MAX_VERTS];
    bit                 on_path [MAX_VERTS];
    int                 stk_v [MAX_VERTS];
    int                 stk_p [MAX_VERTS];

    verdict_t           pending_verdicts [$];
    int                 mismatches = 0;
    int                 words_sent = 0;
    int                 idle_cycles = 0;
    bit                 steady = 1'b0;

    directed_cycle_detect i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .src_vertex    (src_vertex),
        .dst_vertex    (dst_vertex),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cycle_found   (cycle_found),
        .edges_dropped (edges_dropped),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= 15);
    end

    function automatic void enter_vertex(input int v, input int slot);
        seen[v] = 1'b1;
        on_path[v] = 1'b1;
        stk_v[slot] = v;
        stk_p[slot] = int'(adj_head[v]);
    endfunction

    // Iterative depth-first search from every unvisited root; stops at the
    // first edge that reaches a vertex on the current path.
    function automatic bit graph_has_cycle();
        int roots;
        int depth;
        int ptr;
        int nxt;
        roots = (root_limit > MAX_VERTS) ? MAX_VERTS : root_limit;
        for (int v = 0; v < MAX_VERTS; v++)
        begin
            seen[v] = 1'b0;
            on_path[v] = 1'b0;
        end
        for (int r = 0; r < roots; r++)
        begin
            if (!seen[r])
            begin
                enter_vertex(r, 0);
                depth = 1;
                while (depth > 0)
                begin
                    ptr = stk_p[depth - 1];
                    if (ptr == 0)
                    begin
                        on_path[stk_v[depth - 1]] = 1'b0;
                        depth--;
                    end
                    else
                    begin
                        nxt = int'(arc_dst[ptr - 1]);
                        stk_p[depth - 1] = int'(arc_next[ptr - 1]);
                        if (!seen[nxt])
                        begin
                            if (depth < MAX_VERTS)
                            begin
                                enter_vertex(nxt, depth);
                                depth++;
                            end
                        end
                        else if (on_path[nxt])
                        begin
                            return 1'b1;
                        end
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic void apply_word(input logic cmd, input int src, input int dst);
        if (cmd == CMD_ADD)
        begin
            if (arc_count >= MAX_EDGES)
            begin
                arcs_lost = 1'b1;
            end
            else
            begin
                arc_dst[arc_count] = VERT_W'(dst);
                arc_next[arc_count] = adj_head[src];
                adj_head[src] = PTR_W'(arc_count + 1);
                arc_count++;
            end
        end
        else
        begin
            pending_verdicts.push_back('{cycle: graph_has_cycle(), lost: arcs_lost});
            for (int v = 0; v < MAX_VERTS; v++)
            begin
                adj_head[v] = '0;
            end
            arc_count = 0;
            arcs_lost = 1'b0;
        end
    endfunction

    // Valid is only lowered when a gap follows, so a back-to-back word never
    // sees two assignments to in_valid in one step.
    task automatic send_word(input logic cmd, input int src, input int dst);
        int gap;
        gap = 0;
        if (!steady)
        begin
            while ($urandom_range(99) < 15)
            begin
                gap++;
            end
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        src_vertex <= VERT_W'(src);
        dst_vertex <= VERT_W'(dst);
        do
        begin
            @(posedge clk);
        end
        while (in_ready !== 1'b1);
        apply_word(cmd, src, dst);
        words_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reprogram_roots(input int count);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CNT_W'(count);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        root_limit = count;
    endtask

    // Small hand-built graphs: empty, self loop, triangle, diamond and edges
    // that only reach vertices above the root count.
    task automatic test_small_graphs();
        reprogram_roots(4);
        send_word(CMD_DETECT, 0, 0);
        send_word(CMD_ADD, 2, 2);
        send_word(CMD_DETECT, 1023, 1023);
        send_word(CMD_ADD, 0, 1);
        send_word(CMD_ADD, 1, 2);
        send_word(CMD_ADD, 2, 0);
        send_word(CMD_DETECT, 0, 0);
        send_word(CMD_ADD, 0, 1);
        send_word(CMD_ADD, 0, 2);
        send_word(CMD_ADD, 1, 3);
        send_word(CMD_ADD, 2, 3);
        send_word(CMD_DETECT, 0, 0);
        send_word(CMD_ADD, 1023, 1023);
        send_word(CMD_DETECT, 0, 0);
        send_word(CMD_ADD, 0, 1023);
        send_word(CMD_ADD, 1023, 1023);
        send_word(CMD_DETECT, 0, 0);
    endtask

    // A self loop on the top vertex is a root only when the count reaches the
    // vertex range; counts above the range saturate.
    task automatic test_root_count();
        reprogram_roots(2047);
        send_word(CMD_ADD, 1023, 1023);
        send_word(CMD_DETECT, 0, 0);
        reprogram_roots(1023);
        send_word(CMD_ADD, 1023, 1023);
        send_word(CMD_DETECT, 0, 0);
        reprogram_roots(1024);
        send_word(CMD_ADD, 1023, 1023);
        send_word(CMD_DETECT, 0, 0);
        reprogram_roots(0);
        send_word(CMD_ADD, 0, 0);
        send_word(CMD_DETECT, 0, 0);
    endtask

    // Fill the edge store with a long chain, then offer edges that would close
    // a cycle; they must be dropped and flagged once.
    task automatic test_edge_store_full();
        reprogram_roots(1024);
        for (int i = 0; i < MAX_EDGES; i++)
        begin
            send_word(CMD_ADD, i % 1023, i % 1023 + 1);
        end
        send_word(CMD_ADD, 1023, 0);
        send_word(CMD_ADD, 5, 5);
        send_word(CMD_DETECT, 0, 0);
        send_word(CMD_DETECT, 0, 0);
    endtask

    task automatic send_random_graph(input int span_max);
        int span;
        int base;
        int n_arcs;
        int shape;
        int pick;
        int a;
        int b;
        span = $urandom_range(1, span_max);
        pick = $urandom_range(99);
        if (pick < 40)
            base = 0;
        else if (pick < 60)
            base = MAX_VERTS - span;
        else
            base = $urandom_range(0, MAX_VERTS - span);
        n_arcs = $urandom_range(0, 2 * span + 2);
        shape = $urandom_range(SHAPE_DAG, SHAPE_RING);
        if (shape == SHAPE_RING)
        begin
            for (int i = 0; i < span; i++)
            begin
                send_word(CMD_ADD, base + i, base + (i + 1) % span);
            end
        end
        else
        begin
            for (int k = 0; k < n_arcs; k++)
            begin
                a = $urandom_range(0, span - 1);
                b = $urandom_range(0, span - 1);
                if ($urandom_range(9) == 0)
                    send_word(CMD_ADD, $urandom_range(0, 1023), $urandom_range(0, 1023));
                else if (shape == SHAPE_ANY)
                    send_word(CMD_ADD, base + a, base + b);
                else if (a != b)
                    send_word(CMD_ADD, base + ((a < b) ? a : b), base + ((a < b) ? b : a));
            end
            if (shape == SHAPE_DAG_BACK && span > 1)
            begin
                a = $urandom_range(0, span - 2);
                b = $urandom_range(a + 1, span - 1);
                send_word(CMD_ADD, base + b, base + a);
            end
        end
        // Now and then an extra detect word, so the last one sees an empty graph.
        if ($urandom_range(19) == 0)
        begin
            send_word(CMD_DETECT, $urandom_range(0, 1023), $urandom_range(0, 1023));
        end
        send_word(CMD_DETECT, $urandom_range(0, 1023), $urandom_range(0, 1023));
    endtask

    task automatic test_random_graphs();
        int roots;
        int stop_at;
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: roots = $urandom_range(1, 8);
                1: roots = $urandom_range(8, 64);
                2: roots = 1024;
                3: roots = $urandom_range(0, 2047);
                4: roots = $urandom_range(1, 16);
                5: roots = 1;
                6: roots = $urandom_range(16, 200);
                default: roots = $urandom_range(1, 32);
            endcase
            reprogram_roots(roots);
            // One phase runs with no gaps on either side.
            steady = (p == 4);
            stop_at = words_sent + PHASE_WORDS;
            while (words_sent < stop_at)
            begin
                send_random_graph((p == 5) ? 4 : 16);
            end
        end
        steady = 1'b0;
    endtask

    // Results are sampled at the falling edge, where both handshake signals
    // already hold the values seen by the next rising edge.
    always @(negedge clk)
    begin : check_results
        verdict_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result word: expected none, actual cycle_found=%0b "
                         , $time, cycle_found, "edges_dropped=%0b", edges_dropped);
                mismatches++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (cycle_found !== want.cycle)
                begin
                    $display("%0t: cycle_found mismatch: expected %0b, actual %0b",
                             $time, want.cycle, cycle_found);
                    mismatches++;
                end
                if (edges_dropped !== want.lost)
                begin
                    $display("%0t: edges_dropped mismatch: expected %0b, actual %0b",
                             $time, want.lost, edges_dropped);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word accepted for %0d cycles", $time, idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        for (int v = 0; v < MAX_VERTS; v++)
        begin
            adj_head[v] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_small_graphs();
        test_root_count();
        test_edge_store_full();
        test_random_graphs();
        drain_results();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
